@@ hdl/rpt_pkg.sv @@
package rpt_pkg;

  localparam int TIME_W     = 32;
  localparam int RPM_W      = 24;
  localparam int CFG_W      = 24;
  localparam int PPR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int DEN_W      = TIME_W + PPR_W;
  localparam int HISTORY_DEPTH_DEF = 8;

  localparam longint unsigned RPM_SCALE = 64'd960000000;
  localparam logic [RPM_W-1:0] RPM_MAX  = {RPM_W{1'b1}};

  localparam logic [CFG_W-1:0] WINDOW_RST = CFG_W'(100000);
  localparam logic [CFG_W-1:0] STALL_RST  = CFG_W'(400000);
  localparam logic [PPR_W-1:0] PPR_RST    = PPR_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_STALL  = 2'd1,
    CFG_PPR    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEWEST,
    S_FIRST,
    S_CMP,
    S_CHECK,
    S_SETUP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

@@ hdl/rpt_if.sv @@
interface rpt_event_if;
  import rpt_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] event_time;

  modport source (output valid, output kind, output event_time, input ready);
  modport sink   (input valid, input kind, input event_time, output ready);
endinterface

interface rpt_estimate_if;
  import rpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [RPM_W-1:0] rpm_q4;
  logic             too_few_passes;

  modport source (output valid, output rpm_q4, output too_few_passes, input ready);
  modport sink   (input valid, input rpm_q4, input too_few_passes, output ready);
endinterface

@@ hdl/rpt_ram.sv @@
module rpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/revolution_period_tachometer_unit.sv @@
// pass word: written into the ring when accepted; the unit stays ready for the next word
// tick word: the estimate follows a window walk with one ring read per averaged
//   period and the bit-serial divider, both cut short when it is forced to zero;
//   no new word is taken until the estimate is registered
// reset (synchronous): history empty, config back to 100000 / 400000 / 1,
//   ring contents left as they are
module revolution_period_tachometer_unit #(
  parameter int HISTORY_DEPTH = rpt_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  rpt_event_if.sink                     events,
  rpt_estimate_if.source                estimates,
  input  logic                          wr_en,
  input  logic [rpt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [rpt_pkg::CFG_W-1:0]     wr_data
);
  import rpt_pkg::*;

  localparam int SW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int NUM_W  = $clog2(RPM_SCALE * longint'(HISTORY_DEPTH - 1) + 1);
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam logic [CW-1:0]    DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [NUM_W-1:0] SCALE_C = NUM_W'(RPM_SCALE);

  function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] s, input logic [CW-1:0] k);
    logic [CW-1:0] wrapped;
    wrapped = CW'(s) + (DEPTH_C - k);
    if (CW'(s) >= k) begin
      slot_back = SW'(CW'(s) - k);
    end else begin
      slot_back = wrapped[SW-1:0];
    end
  endfunction

  // configuration
  logic [CFG_W-1:0] window_us;
  logic [CFG_W-1:0] stall_timeout_us;
  logic [PPR_W-1:0] magnets_per_rev;
  logic [PPR_W-1:0] ppr_eff;

  // history
  logic [CW-1:0]     held;
  logic [SW-1:0]     newest_slot;
  logic [SW-1:0]     slot_inc;
  logic              ram_we;
  logic [SW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_data;

  // estimate datapath
  state_t               state;
  state_t               state_next;
  logic [TIME_W-1:0]    now;
  logic [TIME_W-1:0]    newest_time;
  logic [TIME_W-1:0]    since;
  logic [TIME_W-1:0]    since_c;
  logic [TIME_W-1:0]    span;
  logic [TIME_W-1:0]    back_diff;
  logic [CW-1:0]        periods;
  logic [CW:0]          p2;
  logic [CW-1:0]        held_eff;
  logic [TIME_W+CW-1:0] over_prod;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     num_init;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     den_init;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 qbit;
  logic [RPM_W-1:0]     quo;
  logic                 ovf;
  logic [CNT_W-1:0]     count;
  logic [RPM_W-1:0]     res_rpm;
  logic                 res_few;

  // output register
  logic             out_valid;
  logic [RPM_W-1:0] out_rpm;
  logic             out_few;
  logic             out_free;

  assign events.ready             = (state == S_IDLE);
  assign estimates.valid          = out_valid;
  assign estimates.rpm_q4         = out_rpm;
  assign estimates.too_few_passes = out_few;
  assign out_free                 = !out_valid || estimates.ready;

  assign ppr_eff   = (magnets_per_rev == '0) ? PPR_W'(1) : magnets_per_rev;
  assign slot_inc  = (newest_slot == SW'(HISTORY_DEPTH - 1)) ? '0 : newest_slot + SW'(1);
  assign ram_we    = events.valid && events.ready && !events.kind;
  assign since_c   = now - rd_data;
  assign held_eff  = (held != '0 && since_c >= TIME_W'(stall_timeout_us)) ? '0 : held;
  assign back_diff = newest_time - rd_data;
  assign p2        = (CW+1)'(periods) + (CW+1)'(2);
  assign over_prod = (TIME_W+CW)'(since) * (TIME_W+CW)'(periods);
  assign num_init  = SCALE_C * NUM_W'(periods);
  assign den_init  = DEN_W'(span) * DEN_W'(ppr_eff);
  assign rem_sh    = {rem, num[NUM_W-1]};
  assign rem_sub   = rem_sh - {1'b0, den};
  assign qbit      = (rem_sh >= {1'b0, den});

  rpt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_inc),
    .wdata (events.event_time),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us        <= WINDOW_RST;
      stall_timeout_us <= STALL_RST;
      magnets_per_rev  <= PPR_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_WINDOW: window_us        <= wr_data;
        CFG_STALL:  stall_timeout_us <= wr_data;
        CFG_PPR:    magnets_per_rev  <= wr_data[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = newest_slot;
    case (state)
      S_IDLE: begin
        if (events.valid && events.kind) begin
          state_next = S_NEWEST;
        end
      end
      S_NEWEST: begin
        rd_addr = slot_back(newest_slot, CW'(1));
        if (held_eff < CW'(2)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        rd_addr = slot_back(newest_slot, CW'(2));
        if (CW'(2) < held) begin
          state_next = S_CMP;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CMP: begin
        rd_addr = slot_back(newest_slot, p2[CW-1:0]);
        if (back_diff > TIME_W'(window_us) || p2 >= {1'b0, held}) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (span == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: state_next = S_DIV;
      S_DIV: begin
        if (count == CNT_W'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // history bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= '0;
      newest_slot <= '0;
    end else if (ram_we) begin
      newest_slot <= slot_inc;
      if (held != DEPTH_C) begin
        held <= held + CW'(1);
      end
    end else if (state == S_NEWEST) begin
      held <= held_eff;
    end
  end

  // estimate datapath, one digit of the divider per cycle
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: now <= events.event_time;
      S_NEWEST: begin
        newest_time <= rd_data;
        since       <= since_c;
        periods     <= CW'(1);
        res_rpm     <= '0;
        res_few     <= 1'b1;
      end
      S_FIRST: begin
        span    <= back_diff;
        res_few <= 1'b0;
      end
      S_CMP: begin
        if (back_diff <= TIME_W'(window_us)) begin
          span    <= back_diff;
          periods <= periods + CW'(1);
        end
      end
      S_CHECK: begin
        if (over_prod > (TIME_W+CW)'(span)) begin
          span    <= since;
          periods <= CW'(1);
        end
      end
      S_SETUP: begin
        num   <= num_init;
        den   <= den_init;
        rem   <= '0;
        quo   <= '0;
        ovf   <= 1'b0;
        count <= CNT_W'(NUM_W);
      end
      S_DIV: begin
        rem   <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo   <= {quo[RPM_W-2:0], qbit};
        ovf   <= ovf | quo[RPM_W-1];
        num   <= {num[NUM_W-2:0], 1'b0};
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          res_rpm <= (ovf || quo[RPM_W-1]) ? RPM_MAX : {quo[RPM_W-2:0], qbit};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (estimates.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_rpm <= res_rpm;
      out_few <= res_few;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= DEPTH_C)
    else $error("held count beyond ring depth");

  a_walk_in_history: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> ((CW+1)'(periods) + (CW+1)'(1)) < {1'b0, held})
    else $error("window walk reads past held passes");

  a_few_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_few |-> out_rpm == '0)
    else $error("estimate nonzero with too few passes");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> count != '0)
    else $error("divider ran past its last digit");

  a_word_after_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> out_valid && state == S_IDLE)
    else $error("finished estimate not registered");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpt_pkg::*;

  localparam logic KIND_PASS = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RING_DEPTH = 8;
  localparam longint unsigned RPM_PER_US_Q4 = 64'd960000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic few;
  } estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  rpt_event_if ev();
  rpt_estimate_if est();

  revolution_period_tachometer_unit dut (
    .clk(clk),
    .rst(rst),
    .events(ev),
    .estimates(est),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // predictor state and configuration
  logic [TIME_W-1:0] pass_ring [RING_DEPTH];
  logic [2:0] head_slot;
  int unsigned passes_held;
  logic [CFG_W-1:0] m_window;
  logic [CFG_W-1:0] m_stall;
  logic [PPR_W-1:0] m_ppr;

  estimate_t rpm_expected[$];
  estimate_t due;
  int errors = 0;
  int cycles = 0;
  logic [TIME_W-1:0] pass_clock = '0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  logic rx_hold = 1'b0;
  event hold_kick;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[revolution_period_tachometer_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      est.ready <= 1'b0;
    end else begin
      est.ready <= !rx_hold && !(rx_idle_on && $urandom_range(99) < 14);
    end
  end

  always begin
    @(hold_kick);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && est.valid && est.ready) begin
      if (rpm_expected.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected estimate word: rpm_q4=%0d too_few_passes=%0b",
                   est.rpm_q4, est.too_few_passes);
        end
      end else begin
        due = rpm_expected[0];
        rpm_expected.delete(0);
        if (est.rpm_q4 !== due.rpm || est.too_few_passes !== due.few) begin
          errors++;
          if (errors <= 10) begin
            $display("estimate mismatch: rpm_q4 exp %0d got %0d, too_few_passes exp %0b got %0b",
                     due.rpm, est.rpm_q4, due.few, est.too_few_passes);
          end
        end
      end
    end
  end

  task automatic track_word(input logic k, input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] newest, since, span;
    logic [2:0] back;
    int unsigned periods;
    longint unsigned quot;
    estimate_t res;
    if (k == KIND_PASS) begin
      head_slot = head_slot + 3'd1;
      pass_ring[head_slot] = t;
      if (passes_held < RING_DEPTH) passes_held++;
    end else begin
      res = '0;
      newest = pass_ring[head_slot];
      since = t - newest;
      periods = 1;
      if (passes_held > 0 && since >= 32'(m_stall)) passes_held = 0;
      if (passes_held < 2) begin
        res.few = 1'b1;
      end else begin
        // widen the span while it stays inside the window
        while (periods + 1 < passes_held) begin
          back = head_slot - 3'(periods + 1);
          if (newest - pass_ring[back] > 32'(m_window)) break;
          periods++;
        end
        back = head_slot - 3'(periods);
        span = newest - pass_ring[back];
        if (span != 0) begin
          if (64'(since) * periods > 64'(span)) begin
            span = since;
            periods = 1;
          end
          quot = (RPM_PER_US_Q4 * periods) /
                 (64'(span) * ((m_ppr == 0) ? 64'd1 : 64'(m_ppr)));
          res.rpm = (quot > 64'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];
        end
      end
      rpm_expected = {rpm_expected, res};
    end
  endtask

  task automatic send_word(input logic k, input logic [TIME_W-1:0] t);
    while (tx_idle_on && $urandom_range(99) < 14) begin
      ev.valid <= 1'b0;
      @(posedge clk);
    end
    ev.valid <= 1'b1;
    ev.kind <= k;
    ev.event_time <= t;
    @(posedge clk);
    while (!ev.ready) @(posedge clk);
    track_word(k, t);
  endtask

  task automatic drain_estimates();
    ev.valid <= 1'b0;
    while (rpm_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] stall,
                            input logic [CFG_W-1:0] ppr_word);
    wr_en <= 1'b1;
    wr_index <= CFG_WINDOW;
    wr_data <= win;
    @(posedge clk);
    wr_index <= CFG_STALL;
    wr_data <= stall;
    @(posedge clk);
    wr_index <= CFG_PPR;
    wr_data <= ppr_word;
    @(posedge clk);
    wr_index <= CFG_SPARE;
    wr_data <= CFG_W'($urandom);
    @(posedge clk);
    wr_en <= 1'b0;
    m_window = win;
    m_stall = stall;
    m_ppr = ppr_word[PPR_W-1:0];
  endtask

  task automatic random_traffic(input int count);
    logic [TIME_W-1:0] period, stamp;
    logic k;
    int unsigned pick;
    int i;
    period = 32'd1000;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0 || $urandom_range(99) < 3) begin
        case ($urandom_range(3))
          0: period = $urandom_range(1, 40);
          1: period = $urandom_range(41, 5000);
          default: period = $urandom_range(5001, 150000);
        endcase
      end
      k = ($urandom_range(99) < 45) ? KIND_TICK : KIND_PASS;
      pick = $urandom_range(99);
      if (pick < 4) pass_clock = $urandom;
      else if (pick < 7) pass_clock = pass_clock + $urandom_range(100000, 3000000);
      if (k == KIND_PASS) begin
        // repeated timestamp now and then
        if (pick >= 7 && pick < 11) stamp = pass_clock;
        else stamp = pass_clock + period - period / 8 + $urandom_range(0, period / 4);
        pass_clock = stamp;
      end else begin
        stamp = pass_clock + $urandom_range(0, 3 * period);
      end
      send_word(k, stamp);
    end
  endtask

  task automatic test_directed();
    int n;
    send_word(KIND_TICK, 32'd0);
    send_word(KIND_TICK, 32'hFFFF_FFFF);
    send_word(KIND_PASS, 32'd1000);
    send_word(KIND_TICK, 32'd1500);
    // equal timestamps give a zero span
    send_word(KIND_PASS, 32'd1000);
    send_word(KIND_TICK, 32'd1200);
    send_word(KIND_PASS, 32'd11000);
    send_word(KIND_PASS, 32'd21000);
    send_word(KIND_PASS, 32'd31000);
    send_word(KIND_TICK, 32'd35000);
    // open interval longer than the mean period
    send_word(KIND_TICK, 32'd81000);
    // stall timeout clears history
    send_word(KIND_TICK, 32'd431000);
    // time wrap and saturation
    send_word(KIND_PASS, 32'hFFFF_FFF0);
    send_word(KIND_PASS, 32'hFFFF_FFFF);
    send_word(KIND_PASS, 32'h0000_0010);
    send_word(KIND_PASS, 32'h0000_0011);
    send_word(KIND_TICK, 32'h0000_0011);
    // more passes than the ring holds
    for (n = 1; n <= 8; n++) send_word(KIND_PASS, 32'h11 + 32'(n) * 32'd5000);
    send_word(KIND_TICK, 32'h11 + 32'd42500);
    pass_clock = 32'h11 + 32'd40000;
  endtask

  task automatic test_register_extremes();
    drain_estimates();
    write_regs('0, '0, {16'($urandom), 8'd0});
    random_traffic(30);
    drain_estimates();
    write_regs({CFG_W{1'b1}}, {CFG_W{1'b1}}, {16'($urandom), 8'hFF});
    random_traffic(30);
    drain_estimates();
    write_regs(CFG_W'(1), CFG_W'(1), {16'($urandom), 8'd1});
    random_traffic(30);
    drain_estimates();
    write_regs(WINDOW_RST, STALL_RST, {16'($urandom), PPR_RST});
    random_traffic(30);
  endtask

  task automatic test_random_stream();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      drain_estimates();
      write_regs(CFG_W'($urandom_range(1, 400000)), CFG_W'($urandom_range(1, 3000000)),
                 {16'($urandom), ($urandom_range(99) < 50) ? 8'($urandom_range(1, 4))
                                                          : 8'($urandom_range(1, 255))});
      random_traffic(50);
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_traffic(60);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_receiver_hold();
    -> hold_kick;
    random_traffic(25);
  endtask

  initial begin
    wr_en = 1'b0;
    wr_index = CFG_WINDOW;
    wr_data = '0;
    ev.valid = 1'b0;
    ev.kind = KIND_PASS;
    ev.event_time = '0;
    for (int j = 0; j < RING_DEPTH; j++) pass_ring[j] = '0;
    head_slot = '0;
    passes_held = 0;
    m_window = WINDOW_RST;
    m_stall = STALL_RST;
    m_ppr = PPR_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_random_stream();
    test_back_to_back();
    test_receiver_hold();
    drain_estimates();
    if (errors == 0) begin
      $display("[revolution_period_tachometer_unit] OK");
    end else begin
      $display("[revolution_period_tachometer_unit] ERROR");
    end
    $finish;
  end

endmodule
